/* hdl/assert_macros.svh */
// Assertion macros for the checker file of the interval table.
// Depends on nothing; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A clocked check that is switched off while reset is held.
`define SIMT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// A clocked check that also holds while reset is held.
`define SIMT_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/simt_pkg.sv */
`timescale 1ns / 1ps
// Shared widths, command and status codes, entry and control types of the interval table.
// Depends on nothing; used by every module of the block.
package simt_pkg;

  localparam int TABLE_DEPTH_DEF = 64;

  localparam int CMD_W    = 2;
  localparam int RUN_W    = 16;
  localparam int RERUN_W  = 10;
  localparam int CAMCOL_W = 3;
  localparam int START_W  = 15;
  localparam int COUNT_W  = 16;
  localparam int IDX_W    = 6;
  localparam int STATUS_W = 3;
  localparam int TOTAL_W  = 7;
  // Signed width for field arithmetic: start plus count plus sign.
  localparam int SUM_W    = 18;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_COVERED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EXTENDED  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_MERGED    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;
  localparam logic [STATUS_W-1:0] ST_READ_OK   = 3'd5;
  localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 3'd6;
  localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd7;

  localparam logic signed [SUM_W-1:0] SUM_ONE   = 18'sd1;
  localparam logic signed [SUM_W-1:0] COUNT_MAX = 18'sd65535;

  typedef struct packed {
    logic [RUN_W-1:0]    run;
    logic [RERUN_W-1:0]  rerun;
    logic [CAMCOL_W-1:0] camcol;
    logic [START_W-1:0]  start;
    logic [COUNT_W-1:0]  count;
  } entry_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    entry_t           ent;
    logic [IDX_W-1:0] idx;
  } item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                capture;
    logic                init_pos;
    logic                rd_last;
    logic                rd_idx;
    logic                rd_back;
    logic                srch_back;
    logic                cap_pred;
    logic                prep;
    logic                wr_upd;
    logic                sh_init;
    logic                sh_step;
    logic                wr_new;
    logic                clr_cnt;
    logic                load_out;
    logic [STATUS_W-1:0] st;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [CMD_W-1:0]    cmd_code;
    logic                cnt_zero;
    logic                idx_ok;
    logic                go_back;
    logic                pos_one;
    logic                pos_at_cnt;
    logic                sh_at_pos;
    logic [STATUS_W-1:0] verdict;
  } dp_stat_t;

  function automatic logic same_key(input entry_t a, input entry_t b);
    return (a.run == b.run) && (a.rerun == b.rerun) && (a.camcol == b.camcol);
  endfunction

  function automatic logic signed [SUM_W-1:0] to_sum(input logic [COUNT_W-1:0] v);
    return $signed(SUM_W'(v));
  endfunction

  function automatic logic [COUNT_W-1:0] sat_count(input logic signed [SUM_W-1:0] v);
    logic [COUNT_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > COUNT_MAX) begin
      r = '1;
    end else begin
      r = v[COUNT_W-1:0];
    end
    return r;
  endfunction

endpackage

/* hdl/simt_ctrl.sv */
`timescale 1ns / 1ps
// Controller state machine of the interval table: sequences search, update, shift and reply.
// Depends on simt_pkg; drives simt_datapath through dp_cmd_t and reads dp_stat_t.
module simt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  simt_pkg::dp_stat_t dp_stat,
  output simt_pkg::dp_cmd_t  dp_cmd
);

  typedef enum logic [9:0] {
    S_IDLE    = 10'b00_0000_0001,
    S_START   = 10'b00_0000_0010,
    S_SEARCH  = 10'b00_0000_0100,
    S_PREP    = 10'b00_0000_1000,
    S_DECIDE  = 10'b00_0001_0000,
    S_SHSTART = 10'b00_0010_0000,
    S_SHIFT   = 10'b00_0100_0000,
    S_INS     = 10'b00_1000_0000,
    S_RDWAIT  = 10'b01_0000_0000,
    S_RESP    = 10'b10_0000_0000
  } state_t;

  state_t                        state_r, state_nxt;
  logic [simt_pkg::STATUS_W-1:0] st_r, st_nxt;
  logic                          out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt   = state_r;
    st_nxt      = st_r;
    dp_cmd      = '0;
    dp_cmd.st   = st_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          dp_cmd.capture = 1'b1;
          state_nxt      = S_START;
        end
      end
      S_START: begin
        case (dp_stat.cmd_code)
          simt_pkg::CMD_INSERT: begin
            dp_cmd.init_pos = 1'b1;
            if (dp_stat.cnt_zero) begin
              state_nxt = S_PREP;
            end else begin
              dp_cmd.rd_last = 1'b1;
              state_nxt      = S_SEARCH;
            end
          end
          simt_pkg::CMD_READ: begin
            if (dp_stat.idx_ok) begin
              dp_cmd.rd_idx = 1'b1;
              st_nxt        = simt_pkg::ST_READ_OK;
              state_nxt     = S_RDWAIT;
            end else begin
              st_nxt    = simt_pkg::ST_BAD_INDEX;
              state_nxt = S_RESP;
            end
          end
          simt_pkg::CMD_CLEAR: begin
            dp_cmd.clr_cnt = 1'b1;
            st_nxt         = simt_pkg::ST_CLEARED;
            state_nxt      = S_RESP;
          end
          default: begin
            st_nxt    = simt_pkg::ST_BAD_INDEX;
            state_nxt = S_RESP;
          end
        endcase
      end
      S_SEARCH: begin
        // The read of the next lower entry is always issued ahead.
        dp_cmd.rd_back = 1'b1;
        if (dp_stat.go_back) begin
          dp_cmd.srch_back = 1'b1;
          if (dp_stat.pos_one) begin
            state_nxt = S_PREP;
          end
        end else begin
          dp_cmd.cap_pred = 1'b1;
          state_nxt       = S_PREP;
        end
      end
      S_PREP: begin
        dp_cmd.prep = 1'b1;
        state_nxt   = S_DECIDE;
      end
      S_DECIDE: begin
        st_nxt = dp_stat.verdict;
        if (dp_stat.verdict == simt_pkg::ST_INSERTED) begin
          state_nxt = S_SHSTART;
        end else begin
          dp_cmd.wr_upd = 1'b1;
          state_nxt     = S_RESP;
        end
      end
      S_SHSTART: begin
        if (dp_stat.pos_at_cnt) begin
          state_nxt = S_INS;
        end else begin
          dp_cmd.rd_last = 1'b1;
          dp_cmd.sh_init = 1'b1;
          state_nxt      = S_SHIFT;
        end
      end
      S_SHIFT: begin
        dp_cmd.sh_step = 1'b1;
        if (dp_stat.sh_at_pos) begin
          state_nxt = S_INS;
        end
      end
      S_INS: begin
        dp_cmd.wr_new = 1'b1;
        state_nxt     = S_RESP;
      end
      S_RDWAIT: begin
        dp_cmd.cap_pred = 1'b1;
        state_nxt       = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          dp_cmd.load_out = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = dp_cmd.load_out | (out_valid_r & ~out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      st_r        <= simt_pkg::ST_INSERTED;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

/* hdl/simt_datapath.sv */
`timescale 1ns / 1ps
// Datapath of the interval table: entry memory, search pointers, merge arithmetic, result word.
// Depends on simt_pkg; commanded by simt_ctrl.
module simt_datapath #(
  parameter int TABLE_DEPTH = simt_pkg::TABLE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [simt_pkg::CMD_W-1:0]    in_cmd,
  input  logic [simt_pkg::RUN_W-1:0]    in_run,
  input  logic [simt_pkg::RERUN_W-1:0]  in_rerun,
  input  logic [simt_pkg::CAMCOL_W-1:0] in_camcol,
  input  logic [simt_pkg::START_W-1:0]  in_start_field,
  input  logic [simt_pkg::COUNT_W-1:0]  in_field_count,
  input  logic [simt_pkg::IDX_W-1:0]    in_read_index,
  input  simt_pkg::dp_cmd_t             dp_cmd,
  output simt_pkg::dp_stat_t            dp_stat,
  output logic [simt_pkg::STATUS_W-1:0] out_status,
  output logic [simt_pkg::RUN_W-1:0]    out_run,
  output logic [simt_pkg::RERUN_W-1:0]  out_rerun,
  output logic [simt_pkg::CAMCOL_W-1:0] out_camcol,
  output logic [simt_pkg::START_W-1:0]  out_start,
  output logic [simt_pkg::COUNT_W-1:0]  out_count,
  output logic [simt_pkg::TOTAL_W-1:0]  out_entry_total
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int XW = (CW > simt_pkg::IDX_W) ? CW : simt_pkg::IDX_W;
  localparam int SW = simt_pkg::SUM_W;

  simt_pkg::entry_t mem_r [TABLE_DEPTH];
  simt_pkg::entry_t mem_q_r;
  simt_pkg::item_t  item_r;
  simt_pkg::entry_t pred_r, succ_r, out_ent_r;
  simt_pkg::entry_t s, wr_data;

  logic [CW-1:0] cnt_r, pos_r;
  logic [AW-1:0] sh_r, rd_addr, wr_addr;
  logic          wr_en;
  logic [1:0]    stage_r, stage_nxt;
  logic [3:0]    back_p;
  logic          go_back;

  logic signed [SW-1:0] last_r, pend_r, pnext_r, nlast_r, nprev_r;
  logic signed [SW-1:0] s_start, mlast;
  logic                 have_pred_r, have_succ_r, full;
  logic [simt_pkg::STATUS_W-1:0] verdict;
  logic [simt_pkg::COUNT_W-1:0]  ext_cnt, merge_cnt;

  logic [simt_pkg::STATUS_W-1:0] out_status_r;
  logic [simt_pkg::TOTAL_W-1:0]  out_total_r;

  assign s = item_r.ent;

  // Search predicates of the four staged backward walks, on the entry just read.
  assign back_p[0] = s.run < mem_q_r.run;
  assign back_p[1] = (s.run == mem_q_r.run) && (s.rerun < mem_q_r.rerun);
  assign back_p[2] = (s.run == mem_q_r.run) && (s.rerun == mem_q_r.rerun) &&
                     (s.camcol < mem_q_r.camcol);
  assign back_p[3] = simt_pkg::same_key(s, mem_q_r) && (s.start < mem_q_r.start);

  // The first walk at or after the current one that still steps back wins.
  always_comb begin
    go_back   = 1'b0;
    stage_nxt = stage_r;
    for (int j = 3; j >= 0; j--) begin
      if ((2'(j) >= stage_r) && back_p[j]) begin
        go_back   = 1'b1;
        stage_nxt = 2'(j);
      end
    end
  end

  assign s_start = simt_pkg::to_sum(simt_pkg::COUNT_W'(s.start));
  assign full    = (cnt_r == CW'(TABLE_DEPTH));

  always_comb begin
    if (have_pred_r && (pend_r >= last_r)) begin
      verdict = simt_pkg::ST_COVERED;
    end else if (have_pred_r && (pnext_r >= s_start)) begin
      verdict = simt_pkg::ST_EXTENDED;
    end else if (have_succ_r && (last_r >= nprev_r)) begin
      verdict = simt_pkg::ST_MERGED;
    end else if (full) begin
      verdict = simt_pkg::ST_FULL;
    end else begin
      verdict = simt_pkg::ST_INSERTED;
    end
  end

  assign ext_cnt   = simt_pkg::sat_count(last_r -
                       simt_pkg::to_sum(simt_pkg::COUNT_W'(pred_r.start)) + simt_pkg::SUM_ONE);
  assign mlast     = (nlast_r > last_r) ? nlast_r : last_r;
  assign merge_cnt = simt_pkg::sat_count(mlast - s_start + simt_pkg::SUM_ONE);

  always_comb begin
    if (dp_cmd.rd_idx) begin
      rd_addr = AW'(item_r.idx);
    end else if (dp_cmd.rd_last) begin
      rd_addr = AW'(cnt_r - CW'(1));
    end else if (dp_cmd.sh_step) begin
      rd_addr = sh_r - AW'(1);
    end else if (dp_cmd.rd_back) begin
      rd_addr = AW'(pos_r - CW'(2));
    end else begin
      rd_addr = '0;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = s;
    if (dp_cmd.wr_new) begin
      wr_en   = 1'b1;
      wr_addr = AW'(pos_r);
    end else if (dp_cmd.sh_step) begin
      wr_en   = 1'b1;
      wr_addr = sh_r + AW'(1);
      wr_data = mem_q_r;
    end else if (dp_cmd.wr_upd && (verdict == simt_pkg::ST_EXTENDED)) begin
      wr_en         = 1'b1;
      wr_addr       = AW'(pos_r - CW'(1));
      wr_data       = pred_r;
      wr_data.count = ext_cnt;
    end else if (dp_cmd.wr_upd && (verdict == simt_pkg::ST_MERGED)) begin
      wr_en         = 1'b1;
      wr_addr       = AW'(pos_r);
      wr_data       = succ_r;
      wr_data.start = s.start;
      wr_data.count = merge_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    mem_q_r <= mem_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (dp_cmd.clr_cnt) begin
      cnt_r <= '0;
    end else if (dp_cmd.wr_new) begin
      cnt_r <= cnt_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.capture) begin
      item_r.cmd        <= in_cmd;
      item_r.ent.run    <= in_run;
      item_r.ent.rerun  <= in_rerun;
      item_r.ent.camcol <= in_camcol;
      item_r.ent.start  <= in_start_field;
      item_r.ent.count  <= in_field_count;
      item_r.idx        <= in_read_index;
    end
    if (dp_cmd.init_pos) begin
      pos_r   <= cnt_r;
      stage_r <= '0;
    end else if (dp_cmd.srch_back) begin
      pos_r   <= pos_r - CW'(1);
      stage_r <= stage_nxt;
    end
    if (dp_cmd.srch_back) begin
      succ_r <= mem_q_r;
    end
    if (dp_cmd.cap_pred) begin
      pred_r <= mem_q_r;
    end
    if (dp_cmd.sh_init) begin
      sh_r <= AW'(cnt_r - CW'(1));
    end else if (dp_cmd.sh_step) begin
      sh_r <= sh_r - AW'(1);
    end
    if (dp_cmd.prep) begin
      last_r  <= s_start + simt_pkg::to_sum(s.count) - simt_pkg::SUM_ONE;
      pnext_r <= simt_pkg::to_sum(simt_pkg::COUNT_W'(pred_r.start)) +
                 simt_pkg::to_sum(pred_r.count);
      pend_r  <= simt_pkg::to_sum(simt_pkg::COUNT_W'(pred_r.start)) +
                 simt_pkg::to_sum(pred_r.count) - simt_pkg::SUM_ONE;
      nlast_r <= simt_pkg::to_sum(simt_pkg::COUNT_W'(succ_r.start)) +
                 simt_pkg::to_sum(succ_r.count) - simt_pkg::SUM_ONE;
      nprev_r <= simt_pkg::to_sum(simt_pkg::COUNT_W'(succ_r.start)) - simt_pkg::SUM_ONE;
      have_pred_r <= (pos_r != '0) && simt_pkg::same_key(s, pred_r);
      have_succ_r <= (pos_r != cnt_r) && simt_pkg::same_key(s, succ_r);
    end
    if (dp_cmd.load_out) begin
      out_status_r <= dp_cmd.st;
      out_total_r  <= simt_pkg::TOTAL_W'(cnt_r);
      if (dp_cmd.st == simt_pkg::ST_READ_OK) begin
        out_ent_r <= pred_r;
      end else begin
        out_ent_r <= '0;
      end
    end
  end

  assign dp_stat.cmd_code   = item_r.cmd;
  assign dp_stat.cnt_zero   = (cnt_r == '0);
  assign dp_stat.idx_ok     = (XW'(item_r.idx) < XW'(cnt_r));
  assign dp_stat.go_back    = go_back;
  assign dp_stat.pos_one    = (pos_r == CW'(1));
  assign dp_stat.pos_at_cnt = (pos_r == cnt_r);
  assign dp_stat.sh_at_pos  = (CW'(sh_r) == pos_r);
  assign dp_stat.verdict    = verdict;

  assign out_status      = out_status_r;
  assign out_run         = out_ent_r.run;
  assign out_rerun       = out_ent_r.rerun;
  assign out_camcol      = out_ent_r.camcol;
  assign out_start       = out_ent_r.start;
  assign out_count       = out_ent_r.count;
  assign out_entry_total = out_total_r;

endmodule

/* hdl/sorted_interval_merge_table.sv */
`timescale 1ns / 1ps
// Sorted interval table: a table of field intervals kept in order of run, rerun, camera
// column and start field, with insert-and-merge, read by index and clear commands.
// Depends on simt_pkg, simt_ctrl and simt_datapath.
//
// Usage. One input word carries a command and its operands on the in_ channel; every word
// gives exactly one result word on the out_ channel, with a status code, the entry read
// (zero for anything but a successful read) and the number of entries left in the table.
// An insert walks backward from the last entry, one entry per cycle through the memory's
// registered read port, then updates one neighbour in place, shifts the tail up by one
// entry per cycle to open a slot, or leaves the table as it is for a covered interval or
// a full table. The next word can be accepted in the cycle after a result is loaded. The
// single memory port pair paces the walk and the shift, and one word is worked on at a time.
// A finished result sits in the output register while the next word is accepted, so a
// stalled receiver only holds up the block once a second result is ready. in_ready is high
// whenever no word is being worked on.
// Reset empties the table at once by clearing the entry count; entry contents are not
// cleared and are never used before they are written. Reset also drops any pending result.
module sorted_interval_merge_table #(
  parameter int TABLE_DEPTH = simt_pkg::TABLE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [simt_pkg::CMD_W-1:0]    in_cmd,
  input  logic [simt_pkg::RUN_W-1:0]    in_run,
  input  logic [simt_pkg::RERUN_W-1:0]  in_rerun,
  input  logic [simt_pkg::CAMCOL_W-1:0] in_camcol,
  input  logic [simt_pkg::START_W-1:0]  in_start_field,
  input  logic [simt_pkg::COUNT_W-1:0]  in_field_count,
  input  logic [simt_pkg::IDX_W-1:0]    in_read_index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [simt_pkg::STATUS_W-1:0] out_status,
  output logic [simt_pkg::RUN_W-1:0]    out_run,
  output logic [simt_pkg::RERUN_W-1:0]  out_rerun,
  output logic [simt_pkg::CAMCOL_W-1:0] out_camcol,
  output logic [simt_pkg::START_W-1:0]  out_start,
  output logic [simt_pkg::COUNT_W-1:0]  out_count,
  output logic [simt_pkg::TOTAL_W-1:0]  out_entry_total
);

  // Command and status words between the controller and the datapath.
  simt_pkg::dp_cmd_t  dp_cmd;
  simt_pkg::dp_stat_t dp_stat;

  // The controller owns the handshakes and the sequence of memory operations.
  simt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dp_stat   (dp_stat),
    .dp_cmd    (dp_cmd)
  );

  // The datapath holds the entry memory, the search and shift pointers and the result word.
  simt_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_cmd          (in_cmd),
    .in_run          (in_run),
    .in_rerun        (in_rerun),
    .in_camcol       (in_camcol),
    .in_start_field  (in_start_field),
    .in_field_count  (in_field_count),
    .in_read_index   (in_read_index),
    .dp_cmd          (dp_cmd),
    .dp_stat         (dp_stat),
    .out_status      (out_status),
    .out_run         (out_run),
    .out_rerun       (out_rerun),
    .out_camcol      (out_camcol),
    .out_start       (out_start),
    .out_count       (out_count),
    .out_entry_total (out_entry_total)
  );

endmodule

/* hdl/simt_checker.sv */
`timescale 1ns / 1ps
// Port-level checks of the interval table and the bind that attaches them to the top level.
// Depends on simt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module simt_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [simt_pkg::STATUS_W-1:0] out_status,
  input logic [simt_pkg::RUN_W-1:0]    out_run,
  input logic [simt_pkg::RERUN_W-1:0]  out_rerun,
  input logic [simt_pkg::CAMCOL_W-1:0] out_camcol,
  input logic [simt_pkg::START_W-1:0]  out_start,
  input logic [simt_pkg::COUNT_W-1:0]  out_count,
  input logic [simt_pkg::TOTAL_W-1:0]  out_entry_total
);

  // A stalled result word keeps its status, entry total and count.
  `SIMT_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_entry_total) && $stable(out_count), "result word changed while stalled")

  // Reset drops any pending result.
  `SIMT_ASSERT_RST(a_reset_flush, clk, !rst_n |=> !out_valid, "result valid after reset")

  // The block is busy straight after it accepts a word.
  `SIMT_ASSERT(a_busy_after_accept, clk, rst_n, in_valid && in_ready |=> !in_ready, "ready straight after an accepted word")

  // A clear leaves an empty table.
  `SIMT_ASSERT(a_clear_empty, clk, rst_n, out_valid && out_status == simt_pkg::ST_CLEARED |-> out_entry_total == '0, "clear reported entries left")

  // Only a successful read carries entry contents.
  `SIMT_ASSERT(a_nonread_zero, clk, rst_n, out_valid && out_status != simt_pkg::ST_READ_OK |-> out_run == '0 && out_rerun == '0 && out_camcol == '0 && out_start == '0 && out_count == '0, "entry fields set on a non-read result")

endmodule

bind sorted_interval_merge_table simt_checker u_simt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_status      (out_status),
  .out_run         (out_run),
  .out_rerun       (out_rerun),
  .out_camcol      (out_camcol),
  .out_start       (out_start),
  .out_count       (out_count),
  .out_entry_total (out_entry_total)
);
